// File: design/mre_pkg.sv
// ----------------------------------------------------------------------------
// mre_pkg: shared types and constants of the mouse report encoder
// Event, mode and encoding codes, register indexes, report characters, the
// shared subtractor result and the report layout lookup.
// ----------------------------------------------------------------------------
package mre_pkg;

   // event kinds carried in the request tuser
   localparam logic [1:0] EV_MOTION  = 2'd0;
   localparam logic [1:0] EV_PRESS   = 2'd1;
   localparam logic [1:0] EV_RELEASE = 2'd2;
   localparam logic [1:0] EV_NONE    = 2'd3;

   // tracking modes
   localparam logic [2:0] MODE_OFF   = 3'd0;
   localparam logic [2:0] MODE_PRESS = 3'd1;
   localparam logic [2:0] MODE_CLICK = 3'd2;
   localparam logic [2:0] MODE_DRAG  = 3'd3;
   localparam logic [2:0] MODE_ANY   = 3'd4;

   // report encodings
   localparam logic [1:0] ENC_DEFAULT = 2'd0;
   localparam logic [1:0] ENC_UTF8    = 2'd1;
   localparam logic [1:0] ENC_SGR     = 2'd2;
   localparam logic [1:0] ENC_URXVT   = 2'd3;

   // register indexes
   localparam logic [2:0] CSR_MODE     = 3'd0;
   localparam logic [2:0] CSR_ENCODING = 3'd1;
   localparam logic [2:0] CSR_BORDER   = 3'd2;
   localparam logic [2:0] CSR_CELL_W   = 3'd3;
   localparam logic [2:0] CSR_CELL_H   = 3'd4;
   localparam logic [2:0] CSR_COLUMNS  = 3'd5;
   localparam logic [2:0] CSR_ROWS     = 3'd6;

   // report characters
   localparam logic [7:0] CH_ESC     = 8'h1B;
   localparam logic [7:0] CH_LBRACK  = 8'h5B;
   localparam logic [7:0] CH_UPPER_M = 8'h4D;
   localparam logic [7:0] CH_LOWER_M = 8'h6D;
   localparam logic [7:0] CH_LESS    = 8'h3C;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_ZERO    = 8'h30;

   // shared unit width: signed pixel minus border needs 17 bits
   localparam int ALU_BITS = 17;
   // quotient bits of the serial divider, last step index
   localparam int QUOT_BITS = 15;
   localparam logic [3:0] DIV_LAST = 4'd14;
   // cell index bits, as set by the 12-bit counts
   localparam int CELL_BITS = 12;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BORDER,
      ST_DIVIDE,
      ST_CLAMP,
      ST_FILTER,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      PK_LIT,
      PK_UTF,
      PK_DEC
   } piece_kind_type;

   typedef struct packed {
      logic [ALU_BITS-1:0] diff;
      logic                neg;
   } alu_out_type;

   typedef struct packed {
      piece_kind_type kind;
      logic [12:0]    value;
      logic           last;
   } piece_type;

   // layout of one report: piece kind, value and final flag by position
   function automatic piece_type piece_info(
      input logic [1:0]  enc,
      input logic [3:0]  idx,
      input logic [7:0]  code,
      input logic [12:0] xv,
      input logic [12:0] yv,
      input logic        rel
   );
      piece_type   p;
      logic [12:0] c32;
      logic [12:0] x32;
      logic [12:0] y32;
      c32 = {5'b0, code} + 13'd32;
      x32 = xv + 13'd32;
      y32 = yv + 13'd32;
      p.kind  = PK_LIT;
      p.value = '0;
      p.last  = 1'b0;
      unique case (enc)
         ENC_DEFAULT, ENC_UTF8: begin
            case (idx)
               4'd0: p.value = {5'b0, CH_ESC};
               4'd1: p.value = {5'b0, CH_LBRACK};
               4'd2: p.value = {5'b0, CH_UPPER_M};
               4'd3: begin p.kind = PK_UTF; p.value = c32; end
               4'd4: begin p.kind = PK_UTF; p.value = x32; end
               4'd5: begin p.kind = PK_UTF; p.value = y32; p.last = 1'b1; end
               default: p.last = 1'b1;
            endcase
         end
         ENC_SGR: begin
            case (idx)
               4'd0: p.value = {5'b0, CH_ESC};
               4'd1: p.value = {5'b0, CH_LBRACK};
               4'd2: p.value = {5'b0, CH_LESS};
               4'd3: begin p.kind = PK_DEC; p.value = {5'b0, code}; end
               4'd4: p.value = {5'b0, CH_SEMI};
               4'd5: begin p.kind = PK_DEC; p.value = xv; end
               4'd6: p.value = {5'b0, CH_SEMI};
               4'd7: begin p.kind = PK_DEC; p.value = yv; end
               4'd8: begin
                  p.value = {5'b0, (rel ? CH_LOWER_M : CH_UPPER_M)};
                  p.last  = 1'b1;
               end
               default: p.last = 1'b1;
            endcase
         end
         default: begin
            case (idx)
               4'd0: p.value = {5'b0, CH_ESC};
               4'd1: p.value = {5'b0, CH_LBRACK};
               4'd2: begin p.kind = PK_DEC; p.value = c32; end
               4'd3: p.value = {5'b0, CH_SEMI};
               4'd4: begin p.kind = PK_DEC; p.value = xv; end
               4'd5: p.value = {5'b0, CH_SEMI};
               4'd6: begin p.kind = PK_DEC; p.value = yv; end
               4'd7: begin p.value = {5'b0, CH_UPPER_M}; p.last = 1'b1; end
               default: p.last = 1'b1;
            endcase
         end
      endcase
      return p;
   endfunction

endpackage

// File: design/mre_alu.sv
// ----------------------------------------------------------------------------
// mre_alu: shared subtractor of the mouse report encoder
// Two's complement difference with a sign flag; serves the border offset,
// each restoring division step and each decimal digit step.
// ----------------------------------------------------------------------------
module mre_alu (
   input  logic [mre_pkg::ALU_BITS-1:0] op_a,
   input  logic [mre_pkg::ALU_BITS-1:0] op_b,
   output mre_pkg::alu_out_type         res
);
   import mre_pkg::*;

   logic [ALU_BITS-1:0] diff;

   // difference, sign taken from the top bit
   assign diff     = op_a - op_b;
   assign res.diff = diff;
   assign res.neg  = diff[ALU_BITS-1];

endmodule

// File: design/mouse_report_encoder.sv
// ----------------------------------------------------------------------------
// mouse_report_encoder: pointer event to terminal mouse report bytes
// Converts a pixel position to a clamped cell, filters by tracking mode and
// streams the escape sequence in default, utf-8, sgr or urxvt form.
// ----------------------------------------------------------------------------
// Flow: per axis a border subtraction, then a 15-step division that is skipped
// for a position inside the border, then clamp and filter; fixed and coded
// bytes go out one byte per cycle while the output slot is free, and decimal
// digits come from repeated subtraction on the shared subtractor.
// A new request is taken only in idle. Reset: synchronous; control and
// configuration registers take their defaults, last cell reads all ones.

module mouse_report_encoder #(
   parameter int COORD_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   // request: tdata = button[3:0], pixel_x[19:4], pixel_y[35:20],
   //          shift_held[36], alt_held[37], ctrl_held[38], zero[39]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,
   // request: tuser = req_type[1:0]
   input  logic [1:0]  req_tuser,
   // response: tdata = out_byte[7:0], tlast = last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast,
   // configuration writes
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_wdata
);
   import mre_pkg::*;

   localparam logic [ALU_BITS-1:0] CapLim = ALU_BITS'(1) << COORD_BITS;

   // decimal weights for the digit loop
   function automatic logic [9:0] dec_weight(input logic [1:0] w);
      logic [9:0] r;
      unique case (w)
         2'd3:    r = 10'd1000;
         2'd2:    r = 10'd100;
         2'd1:    r = 10'd10;
         default: r = 10'd1;
      endcase
      return r;
   endfunction

   // configuration
   logic [2:0]  mode_ff;
   logic [1:0]  enc_ff;
   logic [7:0]  border_ff;
   logic [7:0]  cell_w_ff;
   logic [7:0]  cell_h_ff;
   logic [11:0] columns_ff;
   logic [11:0] rows_ff;

   // control
   state_type   state_ff, state_in;
   logic        axis_ff, axis_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [3:0]  piece_ff, piece_in;
   logic        sub_ff, sub_in;
   logic [1:0]  wi_ff, wi_in;
   logic [3:0]  digit_ff, digit_in;
   logic        started_ff, started_in;
   logic [12:0] last_col_ff, last_col_in;
   logic [12:0] last_row_ff, last_row_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // payload
   logic [1:0]  ev_type_ff, ev_type_in;
   logic [3:0]  button_ff, button_in;
   logic [15:0] pix_x_ff, pix_x_in;
   logic [15:0] pix_y_ff, pix_y_in;
   logic        shift_ff, shift_in;
   logic        alt_ff, alt_in;
   logic        ctrl_ff, ctrl_in;
   logic [QUOT_BITS-1:0] q_ff, q_in;
   logic [7:0]  r_ff, r_in;
   logic [CELL_BITS-1:0] col_ff, col_in;
   logic [CELL_BITS-1:0] row_ff, row_in;
   logic [7:0]  code_ff, code_in;
   logic [12:0] rem_ff, rem_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_last_ff, rsp_last_in;

   // shared unit
   logic [ALU_BITS-1:0] alu_a;
   logic [ALU_BITS-1:0] alu_b;
   alu_out_type         alu;

   mre_alu u_alu (
      .op_a (alu_a),
      .op_b (alu_b),
      .res  (alu)
   );

   // per-axis selections and clamp
   logic [15:0]         pix_sel;
   logic [7:0]          size_sel;
   logic [7:0]          div_eff;
   logic [11:0]         count_sel;
   logic [11:0]         count_eff;
   logic [ALU_BITS-1:0] lim;
   logic [ALU_BITS-1:0] lim_m1;
   logic [ALU_BITS-1:0] q_ext;
   logic [ALU_BITS-1:0] cell_idx;

   assign pix_sel   = axis_ff ? pix_y_ff : pix_x_ff;
   assign size_sel  = axis_ff ? cell_h_ff : cell_w_ff;
   assign div_eff   = (size_sel == 8'd0) ? 8'd1 : size_sel;
   assign count_sel = axis_ff ? rows_ff : columns_ff;
   assign count_eff = (count_sel == 12'd0) ? 12'd1 : count_sel;
   assign lim       = ({5'b0, count_eff} > CapLim) ? CapLim : {5'b0, count_eff};
   assign lim_m1    = lim - ALU_BITS'(1);
   assign q_ext     = {2'b0, q_ff};
   assign cell_idx  = (q_ext > lim_m1) ? lim_m1 : q_ext;

   // event classification and report code
   logic        click;
   logic        rel;
   logic        moved;
   logic        accept;
   logic        range_ok;
   logic [7:0]  code_calc;
   logic [12:0] xv;
   logic [12:0] yv;
   logic [12:0] xv32;
   logic [12:0] yv32;

   assign click = (ev_type_ff == EV_PRESS) || (ev_type_ff == EV_RELEASE);
   assign rel   = ev_type_ff == EV_RELEASE;
   assign moved = ({1'b0, col_ff} != last_col_ff) || ({1'b0, row_ff} != last_row_ff);
   assign xv    = {1'b0, col_ff} + 13'd1;
   assign yv    = {1'b0, row_ff} + 13'd1;
   assign xv32  = xv + 13'd32;
   assign yv32  = yv + 13'd32;

   always_comb begin
      unique case (mode_ff)
         MODE_PRESS: accept = ev_type_ff == EV_PRESS;
         MODE_CLICK: accept = click;
         MODE_DRAG:  accept = click || ((button_ff != 4'd0) && moved);
         MODE_ANY:   accept = click || moved;
         default:    accept = 1'b0;
      endcase
   end

   always_comb begin
      unique case (enc_ff)
         ENC_DEFAULT: range_ok = (xv32 < 13'd256) && (yv32 < 13'd256);
         ENC_UTF8:    range_ok = (xv32 < 13'd2048) && (yv32 < 13'd2048);
         default:     range_ok = 1'b1;
      endcase
   end

   always_comb begin
      code_calc = 8'd0;
      if (click) begin
         priority if (rel && (enc_ff != ENC_SGR)) code_calc = 8'd3;
         else if (button_ff >= 4'd1 && button_ff <= 4'd3)
            code_calc = {4'b0, button_ff - 4'd1};
         else if (button_ff >= 4'd4 && button_ff <= 4'd7)
            code_calc = {6'b010000, button_ff[1:0]};
         else if (button_ff >= 4'd8 && button_ff <= 4'd11)
            code_calc = {6'b100000, button_ff[1:0]};
         else code_calc = 8'd0;
      end else begin
         code_calc = 8'd32;
      end
      if (mode_ff != MODE_PRESS) begin
         code_calc = code_calc | {3'b0, ctrl_ff, alt_ff, shift_ff, 2'b0};
      end
   end

   // current report piece
   piece_type pinfo;
   logic      slot_free;
   logic      two_byte;
   logic      emit;
   logic [7:0] emit_byte;
   logic      emit_last;

   assign pinfo     = piece_info(enc_ff, piece_ff, code_ff, xv, yv, rel);
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign two_byte  = (enc_ff == ENC_UTF8) && (pinfo.value >= 13'd128);

   // sequencer: next state, shared unit operands and byte issue
   always_comb begin
      state_in    = state_ff;
      axis_in     = axis_ff;
      cnt_in      = cnt_ff;
      piece_in    = piece_ff;
      sub_in      = sub_ff;
      wi_in       = wi_ff;
      digit_in    = digit_ff;
      started_in  = started_ff;
      last_col_in = last_col_ff;
      last_row_in = last_row_ff;
      ev_type_in  = ev_type_ff;
      button_in   = button_ff;
      pix_x_in    = pix_x_ff;
      pix_y_in    = pix_y_ff;
      shift_in    = shift_ff;
      alt_in      = alt_ff;
      ctrl_in     = ctrl_ff;
      q_in        = q_ff;
      r_in        = r_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      code_in     = code_ff;
      rem_in      = rem_ff;
      alu_a       = '0;
      alu_b       = '0;
      emit        = 1'b0;
      emit_byte   = '0;
      emit_last   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               ev_type_in = req_tuser;
               button_in  = req_tdata[3:0];
               pix_x_in   = req_tdata[19:4];
               pix_y_in   = req_tdata[35:20];
               shift_in   = req_tdata[36];
               alt_in     = req_tdata[37];
               ctrl_in    = req_tdata[38];
               axis_in    = 1'b0;
               if ((mode_ff != MODE_OFF) && (req_tuser != EV_NONE)) begin
                  state_in = ST_BORDER;
               end
            end
         end
         ST_BORDER: begin
            alu_a = {pix_sel[15], pix_sel};
            alu_b = {9'b0, border_ff};
            if (alu.neg) begin
               q_in     = '0;
               state_in = ST_CLAMP;
            end else begin
               q_in     = alu.diff[QUOT_BITS-1:0];
               r_in     = '0;
               cnt_in   = DIV_LAST;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            // restoring step: one quotient bit
            alu_a  = {8'b0, r_ff, q_ff[QUOT_BITS-1]};
            alu_b  = {9'b0, div_eff};
            q_in   = {q_ff[QUOT_BITS-2:0], ~alu.neg};
            r_in   = alu.neg ? {r_ff[6:0], q_ff[QUOT_BITS-1]} : alu.diff[7:0];
            cnt_in = cnt_ff - 4'd1;
            if (cnt_ff == 4'd0) begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            if (!axis_ff) begin
               col_in   = cell_idx[CELL_BITS-1:0];
               axis_in  = 1'b1;
               state_in = ST_BORDER;
            end else begin
               row_in   = cell_idx[CELL_BITS-1:0];
               state_in = ST_FILTER;
            end
         end
         ST_FILTER: begin
            last_col_in = {1'b0, col_ff};
            last_row_in = {1'b0, row_ff};
            code_in     = code_calc;
            piece_in    = '0;
            sub_in      = 1'b0;
            state_in    = (accept && range_ok) ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            unique case (pinfo.kind)
               PK_LIT: begin
                  if (slot_free) begin
                     emit      = 1'b1;
                     emit_byte = pinfo.value[7:0];
                     emit_last = pinfo.last;
                  end
               end
               PK_UTF: begin
                  if (slot_free) begin
                     emit = 1'b1;
                     if (!sub_ff && two_byte) begin
                        emit_byte = {3'b110, pinfo.value[10:6]};
                        sub_in    = 1'b1;
                     end else if (sub_ff) begin
                        emit_byte = {2'b10, pinfo.value[5:0]};
                        emit_last = pinfo.last;
                     end else begin
                        emit_byte = pinfo.value[7:0];
                        emit_last = pinfo.last;
                     end
                  end
               end
               PK_DEC: begin
                  if (!sub_ff) begin
                     rem_in     = pinfo.value;
                     wi_in      = 2'd3;
                     digit_in   = '0;
                     started_in = 1'b0;
                     sub_in     = 1'b1;
                  end else if (wi_ff == 2'd0) begin
                     // units digit always goes out
                     if (slot_free) begin
                        emit      = 1'b1;
                        emit_byte = CH_ZERO | {4'b0, rem_ff[3:0]};
                     end
                  end else begin
                     alu_a = {4'b0, rem_ff};
                     alu_b = {7'b0, dec_weight(wi_ff)};
                     if (!alu.neg) begin
                        rem_in   = alu.diff[12:0];
                        digit_in = digit_ff + 4'd1;
                     end else if (started_ff || (digit_ff != 4'd0)) begin
                        if (slot_free) begin
                           emit       = 1'b1;
                           emit_byte  = CH_ZERO | {4'b0, digit_ff};
                           started_in = 1'b1;
                           digit_in   = '0;
                           wi_in      = wi_ff - 2'd1;
                        end
                     end else begin
                        // leading zero dropped
                        digit_in = '0;
                        wi_in    = wi_ff - 2'd1;
                     end
                  end
               end
               default: ;
            endcase
            // piece done when its final byte leaves
            if (emit && (sub_in == 1'b0 || sub_ff) &&
                !(pinfo.kind == PK_DEC && wi_ff != 2'd0)) begin
               if (pinfo.last) begin
                  state_in = ST_IDLE;
               end else begin
                  piece_in = piece_ff + 4'd1;
                  sub_in   = 1'b0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // output register
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = emit_byte;
         rsp_last_in  = emit_last;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= 1'b0;
         cnt_ff       <= '0;
         piece_ff     <= '0;
         sub_ff       <= 1'b0;
         wi_ff        <= '0;
         digit_ff     <= '0;
         started_ff   <= 1'b0;
         last_col_ff  <= '1;
         last_row_ff  <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         cnt_ff       <= cnt_in;
         piece_ff     <= piece_in;
         sub_ff       <= sub_in;
         wi_ff        <= wi_in;
         digit_ff     <= digit_in;
         started_ff   <= started_in;
         last_col_ff  <= last_col_in;
         last_row_ff  <= last_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ev_type_ff  <= ev_type_in;
      button_ff   <= button_in;
      pix_x_ff    <= pix_x_in;
      pix_y_ff    <= pix_y_in;
      shift_ff    <= shift_in;
      alt_ff      <= alt_in;
      ctrl_ff     <= ctrl_in;
      q_ff        <= q_in;
      r_ff        <= r_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      code_ff     <= code_in;
      rem_ff      <= rem_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_OFF;
         enc_ff     <= ENC_DEFAULT;
         border_ff  <= 8'd0;
         cell_w_ff  <= 8'd8;
         cell_h_ff  <= 8'd16;
         columns_ff <= 12'd80;
         rows_ff    <= 12'd24;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MODE:     mode_ff    <= csr_wdata[2:0];
            CSR_ENCODING: enc_ff     <= csr_wdata[1:0];
            CSR_BORDER:   border_ff  <= csr_wdata[7:0];
            CSR_CELL_W:   cell_w_ff  <= csr_wdata[7:0];
            CSR_CELL_H:   cell_h_ff  <= csr_wdata[7:0];
            CSR_COLUMNS:  columns_ff <= csr_wdata;
            CSR_ROWS:     rows_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;

   // divider remainder stays below the divisor
   a_div_rem : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (r_ff < div_eff))
      else $error("divider remainder not below divisor");

   // both last-cell registers leave the no-position code together
   a_last_pair : assert property (@(posedge clock) disable iff (reset)
      (last_col_ff == 13'h1FFF) == (last_row_ff == 13'h1FFF))
      else $error("last column and row out of step");

   // units digit is a single decimal digit
   a_units : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && pinfo.kind == PK_DEC && sub_ff && wi_ff == 2'd0)
      |-> (rem_ff < 13'd10))
      else $error("units remainder above nine");

   // clamped row lies inside the screen when filtered
   a_row_clamp : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILTER) |-> ({1'b0, row_ff} < {1'b0, count_eff}))
      else $error("row index beyond row count");

   // a byte is issued only into a free output slot
   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      (emit && rsp_valid_ff) |-> rsp_tready)
      else $error("report byte overwrote a waiting beat");

endmodule
